// ===== src/pta_pkg.sv =====
package pta_pkg;

   // op codes of the request transaction
   localparam logic [1:0] OP_LOAD_ROW   = 2'd0;
   localparam logic [1:0] OP_LOAD_TRANS = 2'd1;
   localparam logic [1:0] OP_AIM        = 2'd2;

   // widths of the datapath
   localparam int CORD_W  = 36;
   localparam int ANGLE_W = 21;
   localparam int DZ_W    = 33;

   // angle limits, Q3.16 radians
   localparam int PI_Q16      = 205887;
   localparam int HALF_PI_Q16 = 102944;
   localparam int PAN_MIN     = -205888;
   localparam int PAN_MAX     = 205887;

   localparam logic [23:0] HEAD_HEIGHT_RESET = 24'd49283;

   typedef logic signed [CORD_W-1:0]  cord_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;

   typedef struct packed {
      cord_type  x;
      cord_type  y;
      angle_type z;
   } vec_type;

   // square root stage contents, pan rotation rides along
   typedef struct packed {
      logic [63:0]     rem;
      logic [63:0]     res;
      vec_type         pan;
      logic [DZ_W-1:0] dz;
      logic            flag;
   } root_type;

   // tilt rotation stage contents
   typedef struct packed {
      vec_type   tilt;
      angle_type pan;
      logic      flag;
   } tilt_type;

   // arctangent of 2^-i in Q16
   function automatic angle_type atan_q16(input int unsigned i);
      angle_type r;
      case (i)
         0:       r = angle_type'(51472);
         1:       r = angle_type'(30386);
         2:       r = angle_type'(16055);
         3:       r = angle_type'(8150);
         4:       r = angle_type'(4091);
         5:       r = angle_type'(2047);
         6:       r = angle_type'(1024);
         7:       r = angle_type'(512);
         8:       r = angle_type'(256);
         9:       r = angle_type'(128);
         10:      r = angle_type'(64);
         11:      r = angle_type'(32);
         12:      r = angle_type'(16);
         13:      r = angle_type'(8);
         14:      r = angle_type'(4);
         15:      r = angle_type'(2);
         16:      r = angle_type'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // one vectoring rotation, shifts round toward minus infinity
   function automatic vec_type cordic_step(input vec_type v, input int unsigned i);
      vec_type  r;
      cord_type xs;
      cord_type ys;
      xs = v.x >>> i;
      ys = v.y >>> i;
      r  = v;
      if (v.y > 0) begin
         r.x = v.x + ys;
         r.y = v.y - xs;
         r.z = v.z + atan_q16(i);
      end else if (v.y < 0) begin
         r.x = v.x - ys;
         r.y = v.y + xs;
         r.z = v.z - atan_q16(i);
      end
      return r;
   endfunction

endpackage

// ===== src/pta_xform.sv =====
module pta_xform
   import pta_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [1:0]         op,
   input  logic [1:0]         row_index,
   input  logic signed [31:0] x_value,
   input  logic signed [31:0] y_value,
   input  logic signed [31:0] z_value,
   input  logic [23:0]        head_height,
   input  logic [3:0]         en,
   output root_type           root_out
);

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;
   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   logic signed [31:0] rot_ff [9];
   logic signed [31:0] trans_ff [3];
   logic signed [31:0] vin [3];

   logic signed [63:0] prod_ff [9];
   logic signed [31:0] trans_s1_ff [3];
   logic signed [31:0] p_ff [3];
   logic signed [31:0] p_in [3];
   logic [63:0]        sq_x_ff, sq_y_ff;
   vec_type            pan_ff, pan_in;
   logic [DZ_W-1:0]    dz_ff, dz_in;
   logic               flag_ff;
   root_type           root_ff;

   assign vin[0] = x_value;
   assign vin[1] = y_value;
   assign vin[2] = z_value;

   // pose store, written by load transactions
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) begin
            rot_ff[k] <= (k == 0 || k == 4 || k == 8) ? ONE : '0;
         end
         for (int k = 0; k < 3; k++) begin
            trans_ff[k] <= '0;
         end
      end else if (accept) begin
         if (op == OP_LOAD_ROW) begin
            for (int r = 0; r < 3; r++) begin
               if (row_index == 2'(r)) begin
                  for (int k = 0; k < 3; k++) begin
                     rot_ff[r*3+k] <= vin[k];
                  end
               end
            end
         end else if (op == OP_LOAD_TRANS) begin
            for (int k = 0; k < 3; k++) begin
               trans_ff[k] <= vin[k];
            end
         end
      end
   end

   // stage 1: nine products against the current pose
   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= 64'(rot_ff[k]) * 64'(vin[k % 3]);
         end
         trans_s1_ff <= trans_ff;
      end
   end

   // stage 2: scale, sum with translation, saturate
   always_comb begin
      logic signed [65:0] acc;
      for (int i = 0; i < 3; i++) begin
         acc = 66'(trans_s1_ff[i]);
         for (int k = 0; k < 3; k++) begin
            acc = acc + 66'(prod_ff[i*3+k] >>> FRACTION_BITS);
         end
         if (acc > SAT_MAX) begin
            p_in[i] = 32'sh7fffffff;
         end else if (acc < SAT_MIN) begin
            p_in[i] = 32'sh80000000;
         end else begin
            p_in[i] = acc[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         p_ff <= p_in;
      end
   end

   // stage 3 set-up: pan half-plane fold and vertical offset
   always_comb begin
      logic signed [33:0] d;
      cord_type           px;
      cord_type           py;
      px = cord_type'(p_ff[0]);
      py = cord_type'(p_ff[1]);
      if (p_ff[0] < 0) begin
         pan_in.x = -px;
         pan_in.y = -py;
         pan_in.z = (p_ff[1] >= 0) ? angle_type'(PI_Q16) : angle_type'(-PI_Q16);
      end else begin
         pan_in.x = px;
         pan_in.y = py;
         pan_in.z = '0;
      end
      d     = 34'(p_ff[2]) - $signed({10'd0, head_height});
      dz_in = (d < 0) ? DZ_W'(-d) : DZ_W'(d);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sq_x_ff <= 64'(p_ff[0]) * 64'(p_ff[0]);
         sq_y_ff <= 64'(p_ff[1]) * 64'(p_ff[1]);
         pan_ff  <= pan_in;
         dz_ff   <= dz_in;
         flag_ff <= (p_ff[0] == '0) && (p_ff[1] == '0);
      end
   end

   // stage 4: squared horizontal distance
   always_ff @(posedge clock) begin
      if (en[3]) begin
         root_ff.rem  <= sq_x_ff + sq_y_ff;
         root_ff.res  <= '0;
         root_ff.pan  <= pan_ff;
         root_ff.dz   <= dz_ff;
         root_ff.flag <= flag_ff;
      end
   end

   assign root_out = root_ff;

endmodule

// ===== src/pta_root_stage.sv =====
module pta_root_stage
   import pta_pkg::*;
#(
   parameter int STEP         = 0,
   parameter int CORDIC_STEPS = 16
) (
   input  logic     clock,
   input  logic     en,
   input  root_type d_in,
   output root_type d_out
);

   localparam logic [63:0] BIT = 64'd1 << (2 * (31 - STEP));

   root_type d_out_in;
   root_type d_out_ff;

   // one root bit, plus one pan rotation while steps remain
   always_comb begin
      d_out_in = d_in;
      if (d_in.rem >= d_in.res + BIT) begin
         d_out_in.rem = d_in.rem - (d_in.res + BIT);
         d_out_in.res = (d_in.res >> 1) + BIT;
      end else begin
         d_out_in.res = d_in.res >> 1;
      end
      if (STEP < CORDIC_STEPS) begin
         d_out_in.pan = cordic_step(d_in.pan, STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_out_ff <= d_out_in;
      end
   end

   assign d_out = d_out_ff;

endmodule

// ===== src/pta_tilt_stage.sv =====
module pta_tilt_stage
   import pta_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     en,
   input  tilt_type d_in,
   output tilt_type d_out
);

   tilt_type d_out_ff;

   // one tilt rotation
   always_ff @(posedge clock) begin
      if (en) begin
         d_out_ff.tilt <= cordic_step(d_in.tilt, STEP);
         d_out_ff.pan  <= d_in.pan;
         d_out_ff.flag <= d_in.flag;
      end
   end

   assign d_out = d_out_ff;

endmodule

// ===== src/pan_tilt_aim_solver_unit.sv =====
// pan/tilt aim solver
// request channel (req_valid / req_stall) carries one transaction per item:
//   op 0 loads rotation row req_row_index, op 1 loads the translation,
//   op 2 aims at the target point (req_x_value, req_y_value, req_z_value).
// load transactions update the pose at acceptance and give no response;
// op 3 and row index 3 are dropped.
// response channel (rsp_valid / rsp_stall) carries pan, tilt and the
// straight-below flag for each aim transaction, in order.
// csr_write_enable / csr_write_data write the head height, Q8.16 metres.
// stages from the accepting edge to rsp_valid: four transform stages
// (the first loads at acceptance), 32 square root stages with pan
// rotations alongside, one tilt stage per step, output reg.
// throughput: one transaction per cycle while req_stall is low.
// each stage holds its own valid bit and takes new data whenever it is
// empty or the next stage moves, so a stalled response only backs up
// the pipeline once all bubbles are filled; nothing is lost or repeated.
// reset clears all valid bits, sets the pose to identity with zero
// translation and the head height to 0.752 m.
module pan_tilt_aim_solver_unit
   import pta_pkg::*;
#(
   parameter int CORDIC_STEPS  = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_op,
   input  logic [1:0]         req_row_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic signed [31:0] req_z_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [18:0] rsp_pan_angle,
   output logic signed [17:0] rsp_tilt_angle,
   output logic               rsp_straight_below,
   input  logic               csr_write_enable,
   input  logic [23:0]        csr_write_data
);

   localparam int ROOT_BASE = 4;
   localparam int TILT_BASE = ROOT_BASE + 32;
   localparam int N_STAGES  = TILT_BASE + CORDIC_STEPS + 1;

   logic [23:0]         head_height_ff;
   logic [N_STAGES-1:0] valid_ff;
   logic [N_STAGES:0]   adv;
   logic                accept;

   root_type            root_data [33];
   tilt_type            tilt_data [CORDIC_STEPS+1];

   logic signed [18:0]  pan_ff;
   logic signed [17:0]  tilt_ff;
   logic                flag_ff;

   // head height register
   always_ff @(posedge clock) begin
      if (reset) begin
         head_height_ff <= HEAD_HEIGHT_RESET;
      end else if (csr_write_enable) begin
         head_height_ff <= csr_write_data;
      end
   end

   // stage advance: a stage moves when empty or when the next one moves
   always_comb begin
      adv[N_STAGES] = !rsp_stall;
      for (int s = N_STAGES - 1; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign req_stall = !adv[0];
   assign accept    = req_valid && !req_stall;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < N_STAGES; s++) begin
            if (adv[s]) begin
               if (s == 0) begin
                  valid_ff[s] <= accept && (req_op == OP_AIM);
               end else begin
                  valid_ff[s] <= valid_ff[s-1];
               end
            end
         end
      end
   end

   // rigid transform and squared distance
   pta_xform #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_xform (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .row_index   (req_row_index),
      .x_value     (req_x_value),
      .y_value     (req_y_value),
      .z_value     (req_z_value),
      .head_height (head_height_ff),
      .en          (adv[3:0]),
      .root_out    (root_data[0])
   );

   // square root with pan rotations alongside
   for (genvar k = 0; k < 32; k++) begin : g_root
      pta_root_stage #(
         .STEP         (k),
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_root (
         .clock (clock),
         .en    (adv[ROOT_BASE+k]),
         .d_in  (root_data[k]),
         .d_out (root_data[k+1])
      );
   end

   // tilt vector from horizontal distance and vertical offset
   assign tilt_data[0].tilt.x = CORD_W'(root_data[32].res[31:0]);
   assign tilt_data[0].tilt.y = CORD_W'(root_data[32].dz);
   assign tilt_data[0].tilt.z = '0;
   assign tilt_data[0].pan    = root_data[32].pan.z;
   assign tilt_data[0].flag   = root_data[32].flag;

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_tilt
      pta_tilt_stage #(
         .STEP (j)
      ) u_tilt (
         .clock (clock),
         .en    (adv[TILT_BASE+j]),
         .d_in  (tilt_data[j]),
         .d_out (tilt_data[j+1])
      );
   end

   // output stage: clamp, negate tilt, straight-below override
   always_ff @(posedge clock) begin
      if (adv[N_STAGES-1]) begin
         if (tilt_data[CORDIC_STEPS].flag) begin
            pan_ff  <= '0;
            tilt_ff <= 18'(-HALF_PI_Q16);
            flag_ff <= 1'b1;
         end else begin
            if (tilt_data[CORDIC_STEPS].pan > PAN_MAX) begin
               pan_ff <= 19'(PAN_MAX);
            end else if (tilt_data[CORDIC_STEPS].pan < PAN_MIN) begin
               pan_ff <= 19'(PAN_MIN);
            end else begin
               pan_ff <= tilt_data[CORDIC_STEPS].pan[18:0];
            end
            if (tilt_data[CORDIC_STEPS].tilt.z < 0) begin
               tilt_ff <= '0;
            end else if (tilt_data[CORDIC_STEPS].tilt.z > HALF_PI_Q16) begin
               tilt_ff <= 18'(-HALF_PI_Q16);
            end else begin
               tilt_ff <= -tilt_data[CORDIC_STEPS].tilt.z[17:0];
            end
            flag_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = valid_ff[N_STAGES-1];
   assign rsp_pan_angle      = pan_ff;
   assign rsp_tilt_angle     = tilt_ff;
   assign rsp_straight_below = flag_ff;

`ifndef ASSERT_OFF
   // load transactions never enter the pipeline
   a_load_no_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op != OP_AIM) |=> !valid_ff[0])
      else $error("load transaction entered the aim pipeline");

   // straight-below responses carry fixed angles
   a_below_angles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_straight_below) |->
         (rsp_pan_angle == '0 && rsp_tilt_angle == 18'(-HALF_PI_Q16)))
      else $error("straight-below response with wrong angles");

   // tilt never points above horizontal
   a_tilt_down: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tilt_angle[17] || rsp_tilt_angle == '0))
      else $error("tilt angle above horizontal");
`endif

endmodule
